// ----- hdl/segment_segment_closest_points_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the closest-points engine
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_CLOSEST_POINTS_TOP_DEFINES_SVH
`define SEGMENT_SEGMENT_CLOSEST_POINTS_TOP_DEFINES_SVH

// same-cycle implication
`define SSCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sscp_pkg.sv -----
// ----------------------------------------------------------------------------
// sscp_pkg
// Shared constants for the segment closest-points pipeline.
// ----------------------------------------------------------------------------
package sscp_pkg;

    localparam int PARAM_BITS = 16;
    localparam int PARAM_W    = PARAM_BITS + 1;
    localparam logic [PARAM_W-1:0] PARAM_ONE = {1'b1, {PARAM_BITS{1'b0}}};

    localparam int THR_W = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd42950;

    localparam int DSQ_W = 64;

    // multiplier slices and fixed latencies of the multiplier and divider units
    localparam int MUL_CHUNK = 32;
    localparam int MUL_LAT   = 5;
    localparam int DIV_LAT   = PARAM_BITS + 1;

endpackage

// ----- hdl/segment_segment_closest_points_top.sv -----
// ----------------------------------------------------------------------------
// segment_segment_closest_points_top
// Closest points between two 3D segments given as signed fixed-point ends.
//
// s_ channel: one query per transfer, twelve coordinates A0, A1, B0, B1.
// m_ channel: one result per query, in order: closest point on each segment,
//   s and t in Q1.16 (65536 = 1) and the squared distance, saturated to 64b.
// cfg channel: degenerate_threshold, always ready; write it while idle.
// Throughput is one query per cycle unless m_tready holds the output. The
// pipeline runs the dot products, second-order products, two 17-stage
// quotient units in series, the point products and the distance products,
// each multiplier five stages deep.
// The whole pipeline advances together; while m_tvalid is high and m_tready
// low it holds, s_tready drops, and nothing is lost or repeated.
// Reset empties the pipeline and sets the threshold to 42950.
// ----------------------------------------------------------------------------
`include "segment_segment_closest_points_top_defines.svh"

module segment_segment_closest_points_top import sscp_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // seg_a_start_x/y/z, seg_a_end_x/y/z, seg_b_start_x/y/z, seg_b_end_x/y/z
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // near_a_x/y/z, near_b_x/y/z, param_a, param_b, dist_sq
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((6*COORD_WIDTH+2*PARAM_W+DSQ_W+7)/8)*8-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [THR_W-1:0]      cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int VW   = CW + 1;
    localparam int PPW  = 2 * VW;
    localparam int DW   = 2 * CW + 4;
    localparam int QW   = 2 * DW;
    localparam int D1W  = QW + 1;
    localparam int SW   = PARAM_W + 1;
    localparam int BSW  = DW + SW;
    localparam int D2W  = DW + SW + 1;
    localparam int AW2  = VW + SW;
    localparam int SQW  = (DW > DSQ_W + 1) ? DW : DSQ_W + 1;
    localparam int MFW  = 6 * CW + 2 * PARAM_W + DSQ_W;
    localparam int MTW  = ((MFW + 7) / 8) * 8;

    // stage numbers along the pipeline
    localparam int ST_DIFF = 1;
    localparam int ST_DOT  = ST_DIFF + MUL_LAT + 1;
    localparam int ST_QUAD = ST_DOT + MUL_LAT;
    localparam int ST_DEN  = ST_QUAD + 1;
    localparam int ST_D1IN = ST_DEN + 1;
    localparam int ST_S1   = ST_D1IN + DIV_LAT;
    localparam int ST_BS   = ST_S1 + MUL_LAT;
    localparam int ST_TNUM = ST_BS + 1;
    localparam int ST_D2IN = ST_TNUM + 1;
    localparam int ST_Q2   = ST_D2IN + DIV_LAT;
    localparam int ST_ST   = ST_Q2 + 1;
    localparam int ST_ALG  = ST_ST + MUL_LAT;
    localparam int ST_PT   = ST_ALG + 1;
    localparam int ST_DF   = ST_PT + 1;
    localparam int ST_SQ   = ST_DF + MUL_LAT;
    localparam int ST_OUT  = ST_SQ + 1;

    localparam logic signed [AW2-1:0] ALG_HALF = AW2'(1) << (PARAM_BITS - 1);

    typedef struct packed {
        logic [2:0][CW-1:0] a0;
        logic [2:0][CW-1:0] b0;
        logic [2:0][VW-1:0] da;
        logic [2:0][VW-1:0] db;
    } geom_t;

    typedef struct packed {
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] e;
        logic signed [DW-1:0] b;
        logic signed [DW-1:0] c;
        logic signed [DW-1:0] f;
    } sums_t;

    typedef struct packed {
        logic dega;
        logic degb;
    } flags_t;

    typedef struct packed {
        sums_t  sm;
        flags_t fl;
    } dots_t;

    typedef struct packed {
        logic               dst_s;
        logic [PARAM_W-1:0] fix;
    } sel_t;

    logic                en;
    logic [ST_OUT:0]     vld_reg;
    logic [THR_W-1:0]    thr_reg;

    logic [12*CW-1:0]    in_reg;
    geom_t               geom1_reg, geom1_next;
    logic [2:0][VW-1:0]  rv1_reg, rv1_next;

    logic signed [PPW-1:0] aa_prod [3];
    logic signed [PPW-1:0] ee_prod [3];
    logic signed [PPW-1:0] bb_prod [3];
    logic signed [PPW-1:0] cc_prod [3];
    logic signed [PPW-1:0] ff_prod [3];

    sums_t               sums7_reg, sums7_next;
    dots_t               dots7, dots31, dots36;
    flags_t              flags13;

    logic signed [QW-1:0] ae_prod, b2_prod, bf_prod, ce_prod;
    logic signed [D1W-1:0] den13_reg, snum13_reg;
    logic signed [D1W-1:0] num14_reg, den14_reg;
    logic [PARAM_W-1:0]  s1_quo, s1_36;
    logic signed [BSW-1:0] bs_prod;

    logic signed [D2W-1:0] tnum37_reg, tden37_reg, nc37_reg, bc37_reg;
    logic signed [D2W-1:0] a37_reg, e37_reg, f37_reg;
    logic [PARAM_W-1:0]  s1_37_reg;
    flags_t              flags37_reg;

    logic signed [D2W-1:0] num38_reg, den38_reg;
    sel_t                sel38_reg, sel55;
    logic [PARAM_W-1:0]  q2_quo;
    logic [PARAM_W-1:0]  s56_reg, t56_reg;
    geom_t               geom56;

    logic signed [AW2-1:0] alg_prod [6];
    logic [5:0][CW-1:0]  base61;
    logic [5:0][CW-1:0]  pt62_reg, pt62_next, pt68;
    logic [2:0][VW-1:0]  df63_reg, df63_next;
    logic signed [PPW-1:0] sq_prod [3];
    logic [2*PARAM_W-1:0] st68;

    logic [6*CW-1:0]     out_pt_reg;
    logic [PARAM_W-1:0]  out_s_reg, out_t_reg;
    logic [DSQ_W-1:0]    out_dist_reg, dist_next;

    // ---------------------------------------------------------------- control
    assign en        = !vld_reg[ST_OUT] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[ST_OUT];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            thr_reg <= THR_RESET;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[ST_OUT-1:0], s_tvalid};
            end
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------ differences
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            geom1_next.a0[k] = in_reg[k*CW +: CW];
            geom1_next.b0[k] = in_reg[(6+k)*CW +: CW];
            geom1_next.da[k] = VW'($signed(in_reg[(3+k)*CW +: CW])) -
                               VW'($signed(in_reg[k*CW +: CW]));
            geom1_next.db[k] = VW'($signed(in_reg[(9+k)*CW +: CW])) -
                               VW'($signed(in_reg[(6+k)*CW +: CW]));
            rv1_next[k]      = VW'($signed(in_reg[k*CW +: CW])) -
                               VW'($signed(in_reg[(6+k)*CW +: CW]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg    <= s_tdata[12*CW-1:0];
            geom1_reg <= geom1_next;
            rv1_reg   <= rv1_next;
        end
    end

    // ----------------------------------------------------- dot products
    for (genvar k = 0; k < 3; k++) begin : g_dot
        sscp_mul #(.AW(VW), .BW(VW)) u_aa (
            .aclk(aclk), .en(en), .op_a($signed(geom1_reg.da[k])),
            .op_b($signed(geom1_reg.da[k])), .prod(aa_prod[k]));
        sscp_mul #(.AW(VW), .BW(VW)) u_ee (
            .aclk(aclk), .en(en), .op_a($signed(geom1_reg.db[k])),
            .op_b($signed(geom1_reg.db[k])), .prod(ee_prod[k]));
        sscp_mul #(.AW(VW), .BW(VW)) u_bb (
            .aclk(aclk), .en(en), .op_a($signed(geom1_reg.da[k])),
            .op_b($signed(geom1_reg.db[k])), .prod(bb_prod[k]));
        sscp_mul #(.AW(VW), .BW(VW)) u_cc (
            .aclk(aclk), .en(en), .op_a($signed(geom1_reg.da[k])),
            .op_b($signed(rv1_reg[k])), .prod(cc_prod[k]));
        sscp_mul #(.AW(VW), .BW(VW)) u_ff (
            .aclk(aclk), .en(en), .op_a($signed(geom1_reg.db[k])),
            .op_b($signed(rv1_reg[k])), .prod(ff_prod[k]));
    end

    always_comb begin
        sums7_next.a = DW'(aa_prod[0]) + DW'(aa_prod[1]) + DW'(aa_prod[2]);
        sums7_next.e = DW'(ee_prod[0]) + DW'(ee_prod[1]) + DW'(ee_prod[2]);
        sums7_next.b = DW'(bb_prod[0]) + DW'(bb_prod[1]) + DW'(bb_prod[2]);
        sums7_next.c = DW'(cc_prod[0]) + DW'(cc_prod[1]) + DW'(cc_prod[2]);
        sums7_next.f = DW'(ff_prod[0]) + DW'(ff_prod[1]) + DW'(ff_prod[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sums7_reg <= sums7_next;
        end
    end

    // squared lengths are never negative, so an unsigned compare is exact
    always_comb begin
        dots7.sm      = sums7_reg;
        dots7.fl.dega = (sums7_reg.a <= DW'(thr_reg));
        dots7.fl.degb = (sums7_reg.e <= DW'(thr_reg));
    end

    // ------------------------------------------- general-case s quotient
    sscp_mul #(.AW(DW), .BW(DW)) u_ae (
        .aclk(aclk), .en(en), .op_a(sums7_reg.a), .op_b(sums7_reg.e), .prod(ae_prod));
    sscp_mul #(.AW(DW), .BW(DW)) u_b2 (
        .aclk(aclk), .en(en), .op_a(sums7_reg.b), .op_b(sums7_reg.b), .prod(b2_prod));
    sscp_mul #(.AW(DW), .BW(DW)) u_bf (
        .aclk(aclk), .en(en), .op_a(sums7_reg.b), .op_b(sums7_reg.f), .prod(bf_prod));
    sscp_mul #(.AW(DW), .BW(DW)) u_ce (
        .aclk(aclk), .en(en), .op_a(sums7_reg.c), .op_b(sums7_reg.e), .prod(ce_prod));

    sscp_delay #(.W($bits(flags_t)), .N(ST_DEN - ST_DOT)) u_dly_flags13 (
        .aclk(aclk), .en(en), .din(dots7.fl), .dout(flags13));

    always_ff @(posedge aclk) begin
        if (en) begin
            den13_reg  <= D1W'(ae_prod) - D1W'(b2_prod);
            snum13_reg <= D1W'(bf_prod) - D1W'(ce_prod);
            // a zero denominator (parallel) or a degenerate case yields 0
            if (!flags13.dega && !flags13.degb && den13_reg != '0) begin
                num14_reg <= snum13_reg;
                den14_reg <= den13_reg;
            end else begin
                num14_reg <= '0;
                den14_reg <= D1W'(1);
            end
        end
    end

    sscp_div #(.W(D1W)) u_div_s (
        .aclk(aclk), .en(en), .num(num14_reg), .den(den14_reg), .quo(s1_quo));

    // --------------------------------------------------- t from quantized s
    sscp_delay #(.W($bits(dots_t)), .N(ST_S1 - ST_DOT)) u_dly_dots31 (
        .aclk(aclk), .en(en), .din(dots7), .dout(dots31));
    sscp_delay #(.W($bits(dots_t)), .N(MUL_LAT)) u_dly_dots36 (
        .aclk(aclk), .en(en), .din(dots31), .dout(dots36));
    sscp_delay #(.W(PARAM_W), .N(MUL_LAT)) u_dly_s36 (
        .aclk(aclk), .en(en), .din(s1_quo), .dout(s1_36));

    sscp_mul #(.AW(DW), .BW(SW)) u_bs (
        .aclk(aclk), .en(en), .op_a(dots31.sm.b), .op_b($signed({1'b0, s1_quo})),
        .prod(bs_prod));

    always_ff @(posedge aclk) begin
        if (en) begin
            tnum37_reg  <= D2W'(bs_prod) + (D2W'(dots36.sm.f) <<< PARAM_BITS);
            tden37_reg  <= D2W'(dots36.sm.e) <<< PARAM_BITS;
            nc37_reg    <= -D2W'(dots36.sm.c);
            bc37_reg    <= D2W'(dots36.sm.b) - D2W'(dots36.sm.c);
            a37_reg     <= D2W'(dots36.sm.a);
            e37_reg     <= D2W'(dots36.sm.e);
            f37_reg     <= D2W'(dots36.sm.f);
            s1_37_reg   <= s1_36;
            flags37_reg <= dots36.fl;
        end
    end

    // pick the one quotient still needed and where its result lands
    always_ff @(posedge aclk) begin
        if (en) begin
            if (flags37_reg.dega && flags37_reg.degb) begin
                num38_reg <= '0;
                den38_reg <= D2W'(1);
                sel38_reg <= '{dst_s: 1'b1, fix: '0};
            end else if (flags37_reg.dega) begin
                num38_reg <= f37_reg;
                den38_reg <= e37_reg;
                sel38_reg <= '{dst_s: 1'b0, fix: '0};
            end else if (flags37_reg.degb || tnum37_reg < 0) begin
                num38_reg <= nc37_reg;
                den38_reg <= a37_reg;
                sel38_reg <= '{dst_s: 1'b1, fix: '0};
            end else if (tnum37_reg > tden37_reg) begin
                num38_reg <= bc37_reg;
                den38_reg <= a37_reg;
                sel38_reg <= '{dst_s: 1'b1, fix: PARAM_ONE};
            end else begin
                num38_reg <= tnum37_reg;
                den38_reg <= tden37_reg;
                sel38_reg <= '{dst_s: 1'b0, fix: s1_37_reg};
            end
        end
    end

    sscp_div #(.W(D2W)) u_div_2 (
        .aclk(aclk), .en(en), .num(num38_reg), .den(den38_reg), .quo(q2_quo));

    sscp_delay #(.W($bits(sel_t)), .N(DIV_LAT)) u_dly_sel55 (
        .aclk(aclk), .en(en), .din(sel38_reg), .dout(sel55));

    always_ff @(posedge aclk) begin
        if (en) begin
            s56_reg <= sel55.dst_s ? q2_quo : sel55.fix;
            t56_reg <= sel55.dst_s ? sel55.fix : q2_quo;
        end
    end

    // ------------------------------------------------------ closest points
    sscp_delay #(.W($bits(geom_t)), .N(ST_ST - ST_DIFF)) u_dly_geom56 (
        .aclk(aclk), .en(en), .din(geom1_reg), .dout(geom56));
    sscp_delay #(.W(6*CW), .N(MUL_LAT)) u_dly_base61 (
        .aclk(aclk), .en(en), .din({geom56.b0, geom56.a0}), .dout(base61));

    for (genvar k = 0; k < 3; k++) begin : g_alg
        sscp_mul #(.AW(VW), .BW(SW)) u_pa (
            .aclk(aclk), .en(en), .op_a($signed(geom56.da[k])),
            .op_b($signed({1'b0, s56_reg})), .prod(alg_prod[k]));
        sscp_mul #(.AW(VW), .BW(SW)) u_pb (
            .aclk(aclk), .en(en), .op_a($signed(geom56.db[k])),
            .op_b($signed({1'b0, t56_reg})), .prod(alg_prod[3+k]));
    end

    // round to nearest, ties up; the point stays between the endpoints
    always_comb begin
        logic signed [AW2-1:0] pt_full;
        for (int k = 0; k < 6; k++) begin
            pt_full      = AW2'($signed(base61[k])) +
                           ((alg_prod[k] + ALG_HALF) >>> PARAM_BITS);
            pt62_next[k] = pt_full[CW-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            df63_next[k] = VW'($signed(pt62_reg[k])) - VW'($signed(pt62_reg[3+k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt62_reg <= pt62_next;
            df63_reg <= df63_next;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_sq
        sscp_mul #(.AW(VW), .BW(VW)) u_sq (
            .aclk(aclk), .en(en), .op_a($signed(df63_reg[k])),
            .op_b($signed(df63_reg[k])), .prod(sq_prod[k]));
    end

    sscp_delay #(.W(6*CW), .N(ST_SQ - ST_PT)) u_dly_pt68 (
        .aclk(aclk), .en(en), .din(pt62_reg), .dout(pt68));
    sscp_delay #(.W(2*PARAM_W), .N(ST_SQ - ST_ST)) u_dly_st68 (
        .aclk(aclk), .en(en), .din({t56_reg, s56_reg}), .dout(st68));

    // ---------------------------------------------------------- output
    always_comb begin
        logic [SQW-1:0] dsum;
        dsum = SQW'(sq_prod[0]) + SQW'(sq_prod[1]) + SQW'(sq_prod[2]);
        if (|dsum[SQW-1:DSQ_W]) begin
            dist_next = '1;
        end else begin
            dist_next = dsum[DSQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_pt_reg   <= pt68;
            out_s_reg    <= st68[PARAM_W-1:0];
            out_t_reg    <= st68[2*PARAM_W-1:PARAM_W];
            out_dist_reg <= dist_next;
        end
    end

    assign m_tdata = MTW'({out_dist_reg, out_t_reg, out_s_reg, out_pt_reg});

    // ------------------------------------------------------- assertions
    `SSCP_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
        "input transfer taken while the result is stalled")
    `SSCP_ASSERT_NOW(a_param_range, vld_reg[ST_ST],
        (s56_reg <= PARAM_ONE) && (t56_reg <= PARAM_ONE),
        "segment parameter above one")
    `SSCP_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0],
        "accepted query did not enter the pipeline")

endmodule

// ----- hdl/sscp_delay.sv -----
// ----------------------------------------------------------------------------
// sscp_delay
// Enabled shift line that carries side data alongside the arithmetic units.
// ----------------------------------------------------------------------------
module sscp_delay import sscp_pkg::*; #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] sr_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= din;
            for (int i = 1; i < N; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[N-1];

endmodule

// ----- hdl/sscp_mul.sv -----
// ----------------------------------------------------------------------------
// sscp_mul
// Pipelined signed multiplier built from 32x32 partial products.
// ----------------------------------------------------------------------------
module sscp_mul import sscp_pkg::*; #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    op_a,
    input  logic signed [BW-1:0]    op_b,
    output logic signed [AW+BW-1:0] prod
);

    localparam int MC  = MUL_CHUNK;
    localparam int NA  = (AW + MC - 1) / MC;
    localparam int NB  = (BW + MC - 1) / MC;
    localparam int AXW = NA * MC;
    localparam int BXW = NB * MC;
    localparam int PW  = AW + BW;
    localparam int RW  = (NB + 1) * MC;
    localparam int TW  = (NA + NB) * MC;

    logic [AXW-1:0]       amag_reg, amag_next;
    logic [BXW-1:0]       bmag_reg, bmag_next;
    logic [3:0]           neg_reg;
    logic [2*MC-1:0]      pp_reg   [NA][NB];
    logic [2*MC-1:0]      pp_next  [NA][NB];
    logic [RW-1:0]        row_reg  [NA];
    logic [RW-1:0]        row_next [NA];
    logic [PW-1:0]        mag_reg, mag_next;
    logic signed [PW-1:0] prod_reg, prod_next;

    always_comb begin
        logic [AW-1:0] a_abs;
        logic [BW-1:0] b_abs;
        a_abs = op_a[AW-1] ? AW'(-op_a) : op_a;
        b_abs = op_b[BW-1] ? BW'(-op_b) : op_b;
        amag_next = AXW'(a_abs);
        bmag_next = BXW'(b_abs);
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                pp_next[i][j] = (2*MC)'(amag_reg[i*MC +: MC]) *
                                (2*MC)'(bmag_reg[j*MC +: MC]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * MC));
            end
        end
    end

    always_comb begin
        logic [TW-1:0] acc;
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            acc = acc + (TW'(row_reg[i]) << (i * MC));
        end
        mag_next = acc[PW-1:0];
    end

    assign prod_next = neg_reg[3] ? -$signed(mag_reg) : $signed(mag_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            amag_reg <= amag_next;
            bmag_reg <= bmag_next;
            neg_reg  <= {neg_reg[2:0], op_a[AW-1] ^ op_b[BW-1]};
            pp_reg   <= pp_next;
            row_reg  <= row_next;
            mag_reg  <= mag_next;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/sscp_div.sv -----
// ----------------------------------------------------------------------------
// sscp_div
// Pipelined clamped quotient num/den in Q1.16, one restoring step per stage.
// ----------------------------------------------------------------------------
module sscp_div import sscp_pkg::*; #(
    parameter int W = 64
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic [PARAM_W-1:0]  quo
);

    localparam int PB = PARAM_BITS;

    logic [W-1:0]    rem_reg  [0:PB];
    logic [W-1:0]    den_reg  [0:PB];
    logic [PB-1:0]   q_reg    [0:PB];
    logic [PB:0]     zero_reg [0:0];
    logic [PB:0]     full_reg [0:0];
    logic [W-1:0]    rem_next [1:PB];
    logic [PB-1:0]   q_next   [1:PB];

    // remainder stays below den, so the doubled value fits in W bits
    always_comb begin
        logic [W-1:0] r2;
        logic         ge;
        for (int k = 1; k <= PB; k++) begin
            r2          = {rem_reg[k-1][W-2:0], 1'b0};
            ge          = (r2 >= den_reg[k-1]);
            rem_next[k] = ge ? (r2 - den_reg[k-1]) : r2;
            q_next[k]   = {q_reg[k-1][PB-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            zero_reg[0] <= {zero_reg[0][PB-1:0], num[W-1] || (num == '0)};
            full_reg[0] <= {full_reg[0][PB-1:0], den <= num};
            for (int k = 1; k <= PB; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    always_comb begin
        if (zero_reg[0][PB]) begin
            quo = '0;
        end else if (full_reg[0][PB]) begin
            quo = PARAM_ONE;
        end else begin
            quo = {1'b0, q_reg[PB]};
        end
    end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Closest points between two 3D segments: block-level testbench
// Queries go in on the s_ stream, and the results are checked field by field
// against a wide-integer model of the same algorithm. The run covers directed
// corner cases, several threshold settings, random traffic under different
// idle and stall mixes, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
    import sscp_pkg::*;

    localparam int CW = 32;
    localparam int S_W = ((12*CW+7)/8)*8;
    localparam int M_W = ((6*CW+2*PARAM_W+DSQ_W+7)/8)*8;
    localparam int PIPE_WAIT = 80;

    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam int ONE = 65536;

    // query shape used by the random generator
    typedef enum int {
        Q_FULL, Q_SMALL, Q_A_POINT, Q_B_POINT, Q_BOTH_POINT, Q_PARALLEL, Q_EXTREME
    } query_kind_t;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [CW-1:0] coords_t [12];

    typedef struct {
        logic signed [CW-1:0] near [6];
        logic [PARAM_W-1:0]   s_par;
        logic [PARAM_W-1:0]   t_par;
        logic [DSQ_W-1:0]     dsq;
    } closest_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata;   // A0 x/y/z, A1 x/y/z, B0 x/y/z, B1 x/y/z
    logic             m_tvalid;
    logic             m_tready;
    logic [M_W-1:0]   m_tdata;   // near_a x/y/z, near_b x/y/z, param_a, param_b, dist_sq
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;

    logic [THR_W-1:0] degen_thr;
    closest_t         pending_results [$];
    int               failures;
    int               send_gap_pct;
    int               stall_pct;
    int               hold_cycles;

    segment_segment_closest_points_top #(.COORD_WIDTH(CW)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic wide_t dot3(wide_t x [3], wide_t y [3]);
        return x[0]*y[0] + x[1]*y[1] + x[2]*y[2];
    endfunction

    // clamped n/d in Q1.16, d > 0
    function automatic logic [PARAM_W-1:0] clamp_quot(wide_t n, wide_t d);
        wide_t q;
        if (n <= 0) return '0;
        if (d <= n) return PARAM_ONE;
        q = (n * 65536) / d;
        return q[PARAM_W-1:0];
    endfunction

    function automatic wide_t point_on(wide_t base, wide_t dir, logic [PARAM_W-1:0] p);
        wide_t pw;
        pw = '0;
        pw[PARAM_W-1:0] = p;
        return base + ((dir * pw + 32768) >>> 16);
    endfunction

    function automatic closest_t closest_points(coords_t q);
        wide_t a0 [3], b0 [3], da [3], db [3], rv [3], df [3];
        wide_t pa, pb, a, e, b, c, f, thr, denom, tnum, tden, sw, dsq_full;
        logic [PARAM_W-1:0] s, t;
        logic dega, degb;
        closest_t r;
        for (int k = 0; k < 3; k++) begin
            a0[k] = q[k];
            b0[k] = q[6+k];
            da[k] = q[3+k];
            da[k] = da[k] - a0[k];
            db[k] = q[9+k];
            db[k] = db[k] - b0[k];
            rv[k] = a0[k] - b0[k];
        end
        a = dot3(da, da);
        e = dot3(db, db);
        c = dot3(da, rv);
        f = dot3(db, rv);
        thr = '0;
        thr[THR_W-1:0] = degen_thr;
        dega = (a <= thr);
        degb = (e <= thr);
        if (dega && degb) begin
            s = '0;
            t = '0;
        end else if (dega) begin
            s = '0;
            t = clamp_quot(f, e);
        end else if (degb) begin
            t = '0;
            s = clamp_quot(-c, a);
        end else begin
            b = dot3(da, db);
            denom = a*e - b*b;
            s = (denom == 0) ? '0 : clamp_quot(b*f - c*e, denom);
            sw = '0;
            sw[PARAM_W-1:0] = s;
            tnum = b*sw + f*65536;
            tden = e*65536;
            if (tnum < 0) begin
                t = '0;
                s = clamp_quot(-c, a);
            end else if (tnum > tden) begin
                t = PARAM_ONE;
                s = clamp_quot(b - c, a);
            end else begin
                t = clamp_quot(tnum, tden);
            end
        end
        for (int k = 0; k < 3; k++) begin
            pa = point_on(a0[k], da[k], s);
            pb = point_on(b0[k], db[k], t);
            df[k] = pa - pb;
            r.near[k] = pa[CW-1:0];
            r.near[3+k] = pb[CW-1:0];
        end
        dsq_full = dot3(df, df);
        r.s_par = s;
        r.t_par = t;
        r.dsq = (|dsq_full[255:DSQ_W]) ? '1 : dsq_full[DSQ_W-1:0];
        return r;
    endfunction

    // drive inputs on the falling edge
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        closest_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("near_a_x", 64'($unsigned(want.near[0])),
                            64'(m_tdata[0*CW +: CW]));
                check_field("near_a_y", 64'($unsigned(want.near[1])),
                            64'(m_tdata[1*CW +: CW]));
                check_field("near_a_z", 64'($unsigned(want.near[2])),
                            64'(m_tdata[2*CW +: CW]));
                check_field("near_b_x", 64'($unsigned(want.near[3])),
                            64'(m_tdata[3*CW +: CW]));
                check_field("near_b_y", 64'($unsigned(want.near[4])),
                            64'(m_tdata[4*CW +: CW]));
                check_field("near_b_z", 64'($unsigned(want.near[5])),
                            64'(m_tdata[5*CW +: CW]));
                check_field("param_a", 64'(want.s_par), 64'(m_tdata[6*CW +: PARAM_W]));
                check_field("param_b", 64'(want.t_par),
                            64'(m_tdata[6*CW+PARAM_W +: PARAM_W]));
                check_field("dist_sq", want.dsq, m_tdata[6*CW+2*PARAM_W +: DSQ_W]);
            end
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic send_query(coords_t q);
        s_tvalid <= 1'b1;
        for (int i = 0; i < 12; i++) s_tdata[i*CW +: CW] <= q[i];
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(closest_points(q));
        @(negedge aclk);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_WAIT) @(negedge aclk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        degen_thr = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int small_coord();
        return int'($urandom_range(0, 2097152)) - 1048576;
    endfunction

    function automatic coords_t make_query(query_kind_t kind);
        coords_t q;
        int pick;
        for (int i = 0; i < 12; i++) q[i] = (kind == Q_FULL) ? $urandom : small_coord();
        case (kind)
            Q_A_POINT, Q_BOTH_POINT: begin
                for (int k = 0; k < 3; k++) q[3+k] = q[k] + int'($urandom_range(0, 200)) - 100;
            end
            default: ;
        endcase
        case (kind)
            Q_B_POINT, Q_BOTH_POINT: begin
                for (int k = 0; k < 3; k++) q[9+k] = q[6+k] + int'($urandom_range(0, 200)) - 100;
            end
            Q_PARALLEL: begin
                for (int k = 0; k < 3; k++) q[9+k] = q[6+k] + (q[3+k] - q[k]);
            end
            Q_EXTREME: begin
                for (int i = 0; i < 12; i++) begin
                    pick = $urandom_range(4);
                    q[i] = (pick == 0) ? CMIN : (pick == 1) ? CMAX : pick - 3;
                end
            end
            default: ;
        endcase
        return q;
    endfunction

    function automatic coords_t pair(int ax0, int ay0, int az0, int ax1, int ay1, int az1,
                                     int bx0, int by0, int bz0, int bx1, int by1, int bz1);
        coords_t q;
        q = '{ax0, ay0, az0, ax1, ay1, az1, bx0, by0, bz0, bx1, by1, bz1};
        return q;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_query(make_query(query_kind_t'($urandom_range(0, 6))));
    endtask

    task automatic test_directed();
        coords_t q;
        send_gap_pct = 0;
        stall_pct = 0;
        // both segments collapse to points
        send_query(pair(0,0,0, 0,0,0, 0,0,0, 0,0,0));
        // far-apart points: distance saturates; then two extreme coinciding pairs
        for (int i = 0; i < 12; i++) q[i] = (i < 6) ? CMIN : CMAX;
        send_query(q);
        for (int i = 0; i < 12; i++) q[i] = (i % 2) ? CMIN : CMAX;
        send_query(q);
        for (int i = 0; i < 12; i++) q[i] = (i < 3 || i >= 9) ? CMAX : CMIN;
        send_query(q);
        // A is a point
        send_query(pair(ONE,ONE,0, ONE,ONE,0, 0,0,0, 2*ONE,0,0));
        send_query(pair(-5*ONE,0,0, -5*ONE,0,0, 0,0,0, 2*ONE,0,0));
        send_query(pair(9*ONE,0,0, 9*ONE,0,0, 0,0,0, 2*ONE,0,0));
        // B is a point
        send_query(pair(0,0,0, 4*ONE,0,0, ONE,3*ONE,0, ONE,3*ONE,0));
        send_query(pair(0,0,0, 4*ONE,0,0, -ONE,ONE,ONE, -ONE,ONE,ONE));
        send_query(pair(0,0,0, 4*ONE,0,0, 7*ONE,ONE,0, 7*ONE,ONE,0));
        // crossing segments
        send_query(pair(-ONE,0,0, ONE,0,0, 0,-ONE,ONE, 0,ONE,ONE));
        send_query(pair(0,0,0, 3*ONE,ONE,2*ONE, ONE,-2*ONE,5, -ONE,2*ONE,ONE));
        // parallel
        send_query(pair(0,0,0, ONE,0,0, 0,ONE,0, ONE,ONE,0));
        send_query(pair(0,0,0, ONE,ONE,ONE, 3*ONE,0,0, 4*ONE,ONE,ONE));
        // t falls below zero, then above one
        send_query(pair(0,0,0, ONE,0,0, 2*ONE,ONE,0, 5*ONE,2*ONE,0));
        send_query(pair(0,0,0, ONE,0,0, -5*ONE,-2*ONE,ONE, -2*ONE,-ONE,ONE));
        send_query(pair(0,0,0, ONE,0,0, -5*ONE,ONE,0, -2*ONE,2*ONE,0));
        // near the degenerate threshold (42950 ~ 207^2), then extreme and tiny diagonals
        send_query(pair(0,0,0, 207,0,0, ONE,0,0, ONE,ONE,0));
        send_query(pair(0,0,0, 208,0,0, ONE,0,0, ONE,ONE,0));
        send_query(pair(0,0,0, ONE,0,0, 0,ONE,0, 0,ONE,207));
        send_query(pair(CMIN,CMIN,CMIN, CMAX,CMAX,CMAX, CMAX,CMIN,CMAX, CMIN,CMAX,CMIN));
        send_query(pair(CMAX,CMAX,CMAX, CMIN,CMIN,CMIN, CMAX,CMAX,CMAX, CMIN,CMIN,CMIN));
        send_query(pair(-1,-1,-1, 1,1,1, 1,-1,1, -1,1,-1));
    endtask

    task automatic test_thresholds();
        send_gap_pct = 19;
        stall_pct = 19;
        write_threshold('0);
        send_random(60);
        write_threshold('1);
        send_random(40);
        write_threshold(32'(ONE) * 32'(ONE / 2));
        send_random(40);
        write_threshold($urandom);
        send_random(40);
        write_threshold(THR_RESET);
    endtask

    task automatic test_idle_mix();
        send_gap_pct = 0;  stall_pct = 0;  send_random(300);
        send_gap_pct = 49; stall_pct = 0;  send_random(200);
        send_gap_pct = 0;  stall_pct = 49; send_random(200);
        send_gap_pct = 19; stall_pct = 19; send_random(200);
    endtask

    task automatic test_backpressure();
        send_gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 300;
        send_random(150);
    endtask

    task automatic test_drain_pause();
        send_gap_pct = 10;
        stall_pct = 10;
        send_random(40);
        wait_drain();
        send_random(40);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        degen_thr = THR_RESET;
        failures = 0;
        send_gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_thresholds();
        test_idle_mix();
        test_backpressure();
        test_drain_pause();
        wait_drain();

        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
